>>> design/peer_liveness_table_assert.svh
// Assertion macros used by the peer liveness table engine.
`ifndef PEER_LIVENESS_TABLE_ASSERT_SVH
`define PEER_LIVENESS_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PLT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/plt_pkg.sv
// Types, constants and codes for the peer liveness table.
`default_nettype none
package plt_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 16;
	localparam logic [31:0] WINDOW_RESET      = 32'd10000000;
	localparam int unsigned SAT_MAX           = 31;
	localparam int unsigned CFG_IDX_W         = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OWN_NODE_ID  = 1'b0,
		REG_ALIVE_WINDOW = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] heard_id;
		logic [62:0] now_time;
	} plt_in_t;

	typedef struct packed {
		logic [4:0] node_count;
		logic [4:0] own_rank;
		logic       dropped;
	} plt_out_t;

	// Heartbeat after classification, as queued for the table engine.
	typedef struct packed {
		logic [31:0] heard_id;
		logic [62:0] now_time;
		logic [62:0] cutoff;
		logic        has_cutoff;
		logic        is_self;
	} plt_task_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_UPDATE
	} plt_state_t;

endpackage
`default_nettype wire

>>> design/plt_front.sv
// Front end: accepts heartbeats, classifies them and queues them for the engine.
`default_nettype none
module plt_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire plt_pkg::plt_in_t   in_data,
	input  wire logic [31:0]        own_node_id,
	input  wire logic [31:0]        alive_window,
	output logic                    task_valid,
	input  wire logic               task_pop,
	output plt_pkg::plt_task_t      task_data
);
	import plt_pkg::*;

	plt_task_t  q_mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	logic [63:0] diff;
	plt_task_t  cls;

	// Borrow out of the subtract means the window reaches below time zero.
	assign diff = {1'b0, in_data.now_time} - {32'b0, alive_window};

	always_comb begin
		cls.heard_id   = in_data.heard_id;
		cls.now_time   = in_data.now_time;
		cls.cutoff     = diff[62:0];
		cls.has_cutoff = !diff[63];
		cls.is_self    = (in_data.heard_id == own_node_id);
	end

	assign in_stall   = (cnt_q == 2'd2);
	assign task_valid = (cnt_q != 2'd0);
	assign task_data  = q_mem[rd_ptr_q];
	assign push       = in_valid && !in_stall;
	assign pop        = task_pop && task_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/plt_engine.sv
// Table engine: sweeps the peer table to purge, match, count and rank, then updates it.
`default_nettype none
`include "peer_liveness_table_assert.svh"
module plt_engine #(
	parameter int unsigned TABLE_ENTRIES = plt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [31:0]        own_node_id,
	input  wire logic               task_valid,
	output logic                    task_pop,
	input  wire plt_pkg::plt_task_t task_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output plt_pkg::plt_out_t       out_data
);
	import plt_pkg::*;

	localparam int unsigned IDXW = $clog2(TABLE_ENTRIES);
	localparam int unsigned CNTW = $clog2(TABLE_ENTRIES + 2);
	localparam int unsigned SATW = CNTW + 5;

	plt_state_t             state_q, state_d;
	plt_task_t              item_q;
	logic [31:0]            id_mem   [TABLE_ENTRIES];
	logic [62:0]            seen_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;

	logic [IDXW:0]          rd_cnt_q;
	logic                   rd_vld_s1;
	logic [IDXW-1:0]        rd_idx_s1;
	logic [31:0]            rd_id_s1;
	logic [62:0]            rd_seen_s1;

	logic [CNTW-1:0]        count_q;
	logic [CNTW-1:0]        rank_q;
	logic                   match_found_q;
	logic [IDXW-1:0]        match_idx_q;
	logic                   free_found_q;
	logic [IDXW-1:0]        free_idx_q;

	logic                   out_valid_q;
	plt_out_t               out_q;

	logic                   out_free;
	logic                   in_update;
	logic                   rd_issue;
	logic                   sweep_done;
	logic                   fin;
	logic                   ent_valid;
	logic                   ent_purge;
	logic                   ent_live;
	logic                   do_refresh;
	logic                   do_insert;
	logic                   do_drop;
	logic                   ins_lower;
	logic                   seen_we;
	logic [IDXW-1:0]        wr_idx;
	logic [CNTW-1:0]        node_full;
	logic [CNTW-1:0]        rank_full;
	logic [SATW-1:0]        node_ext;
	logic [SATW-1:0]        rank_ext;
	plt_out_t               result;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_update  = (state_q == ST_UPDATE);
	assign sweep_done = (rd_cnt_q == (IDXW+1)'(TABLE_ENTRIES)) && !rd_vld_s1;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (task_valid) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sweep_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		task_pop = 1'b0;
		rd_issue = 1'b0;
		fin      = 1'b0;
		unique case (state_q)
			ST_IDLE:   task_pop = 1'b1;
			ST_SWEEP:  rd_issue = (rd_cnt_q != (IDXW+1)'(TABLE_ENTRIES));
			ST_UPDATE: fin = out_free;
			default: begin
				task_pop = 1'b0;
			end
		endcase
	end

	// Entry under inspection, in the cycle after its read
	assign ent_valid = valid_q[rd_idx_s1];
	assign ent_purge = (item_q.has_cutoff && (rd_seen_s1 < item_q.cutoff))
		|| (rd_id_s1 == own_node_id);
	assign ent_live  = ent_valid && !ent_purge;

	assign do_refresh = !item_q.is_self && match_found_q;
	assign do_insert  = !item_q.is_self && !match_found_q && free_found_q;
	assign do_drop    = !item_q.is_self && !match_found_q && !free_found_q;
	assign ins_lower  = (item_q.heard_id < own_node_id);
	assign seen_we    = fin && (do_refresh || do_insert);
	assign wr_idx     = do_refresh ? match_idx_q : free_idx_q;

	assign node_full = count_q + CNTW'(do_insert) + CNTW'(1);
	assign rank_full = rank_q + CNTW'(do_insert && ins_lower);
	assign node_ext  = SATW'(node_full);
	assign rank_ext  = SATW'(rank_full);

	always_comb begin
		result.node_count = (node_ext > SATW'(SAT_MAX)) ? 5'(SAT_MAX) : node_ext[4:0];
		result.own_rank   = (rank_ext > SATW'(SAT_MAX)) ? 5'(SAT_MAX) : rank_ext[4:0];
		result.dropped    = do_drop;
	end

	// Table storage: one read port, one write port, registered read
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_id_s1   <= id_mem[rd_cnt_q[IDXW-1:0]];
			rd_seen_s1 <= seen_mem[rd_cnt_q[IDXW-1:0]];
		end
		if (seen_we) begin
			seen_mem[wr_idx] <= item_q.now_time;
		end
		if (fin && do_insert) begin
			id_mem[free_idx_q] <= item_q.heard_id;
		end
	end

	always_ff @(posedge clk) begin
		if (task_pop && task_valid) begin
			item_q <= task_data;
		end
		rd_idx_s1 <= rd_cnt_q[IDXW-1:0];
		if (fin) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			valid_q       <= '0;
			rd_cnt_q      <= '0;
			rd_vld_s1     <= 1'b0;
			count_q       <= '0;
			rank_q        <= '0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
			free_found_q  <= 1'b0;
			free_idx_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;
			if (task_pop && task_valid) begin
				rd_cnt_q      <= '0;
				count_q       <= '0;
				rank_q        <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
			end
			if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + (IDXW+1)'(1);
			end
			if (rd_vld_s1) begin
				if (ent_valid && ent_purge) begin
					valid_q[rd_idx_s1] <= 1'b0;
				end
				if (ent_live) begin
					count_q <= count_q + CNTW'(1);
					rank_q  <= rank_q + CNTW'(rd_id_s1 < own_node_id);
					if (!match_found_q && (rd_id_s1 == item_q.heard_id)) begin
						match_found_q <= 1'b1;
						match_idx_q   <= rd_idx_s1;
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= rd_idx_s1;
				end
			end
			if (fin) begin
				out_valid_q <= 1'b1;
				if (do_insert) begin
					valid_q[free_idx_q] <= 1'b1;
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PLT_ASSERT_NOW(a_match_live, in_update && match_found_q, valid_q[match_idx_q], "stale match")
	`PLT_ASSERT_NOW(a_free_empty, in_update && free_found_q, !valid_q[free_idx_q], "free slot taken")
	`PLT_ASSERT_NOW(a_drop_full, fin && do_drop, count_q == CNTW'(TABLE_ENTRIES), "drop with room")
	`PLT_ASSERT_NEXT(a_insert_set, fin && do_insert, valid_q[$past(free_idx_q)], "insert not set")

endmodule
`default_nettype wire

>>> design/peer_liveness_table.sv
// Heartbeats are handled one at a time by the engine's single-port sweep, which reads one
// table entry per cycle; a two-deep input queue takes heartbeats meanwhile.
// Reset: valid bits cleared, queue and result emptied, own_node_id 0, alive_window 10000000.
// Entry ids and times are not cleared; no clearing pass runs after reset.
`default_nettype none
module peer_liveness_table #(
	parameter int unsigned TABLE_ENTRIES = plt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [plt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                     cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire plt_pkg::plt_in_t                in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output plt_pkg::plt_out_t                    out_data
);
	import plt_pkg::*;

	logic [31:0] own_id_q;
	logic [31:0] window_q;
	logic        task_valid;
	logic        task_pop;
	plt_task_t   task_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
			window_q <= WINDOW_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_OWN_NODE_ID:  own_id_q <= cfg_data;
				REG_ALIVE_WINDOW: window_q <= cfg_data;
				default: begin
					own_id_q <= own_id_q;
				end
			endcase
		end
	end

	plt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.own_node_id  (own_id_q),
		.alive_window (window_q),
		.task_valid   (task_valid),
		.task_pop     (task_pop),
		.task_data    (task_data)
	);

	plt_engine #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.own_node_id (own_id_q),
		.task_valid  (task_valid),
		.task_pop    (task_pop),
		.task_data   (task_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule
`default_nettype wire

>>> tb/sv/peer_liveness_table_tb.sv
// Self-checking testbench for the peer liveness table: stimulus, table predictor, result check.
`default_nettype none
module peer_liveness_table_tb;
	import plt_pkg::*;

	localparam int unsigned NPEERS   = TABLE_ENTRIES_DEF;
	localparam logic [63:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int          MAX_GAP  = 12;
	localparam int          SETTLE   = NPEERS + 8;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_OWN_NODE_ID;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	plt_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	plt_out_t out_data;

	peer_liveness_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predicted table and register copies
	bit          peer_live [NPEERS];
	logic [31:0] peer_id   [NPEERS];
	logic [62:0] peer_seen [NPEERS];
	logic [31:0] own_id_cfg = 32'd0;
	logic [31:0] window_cfg = WINDOW_RESET;

	plt_in_t  hb_queue [$];
	plt_out_t outcome_q [$];
	int       queued_count = 0;
	int       taken_count = 0;
	int       results_taken = 0;
	int       err_count = 0;
	bit       hold_out = 1'b0;

	function automatic plt_out_t heartbeat_outcome(plt_in_t hb);
		logic [62:0] cutoff;
		bit          aging;
		int          hit;
		int          hole;
		int unsigned live;
		int unsigned below;
		plt_out_t    res;
		aging = hb.now_time >= {31'b0, window_cfg};
		cutoff = hb.now_time - {31'b0, window_cfg};
		hit = -1;
		hole = -1;
		live = 0;
		below = 0;
		res = '0;
		for (int i = 0; i < NPEERS; i++)
			if (peer_live[i] && ((aging && peer_seen[i] < cutoff) || peer_id[i] == own_id_cfg))
				peer_live[i] = 1'b0;
		for (int i = 0; i < NPEERS; i++) begin
			if (peer_live[i]) begin
				if (hit < 0 && peer_id[i] == hb.heard_id)
					hit = i;
			end else if (hole < 0) begin
				hole = i;
			end
		end
		if (hb.heard_id != own_id_cfg) begin
			if (hit >= 0) begin
				peer_seen[hit] = hb.now_time;
			end else if (hole >= 0) begin
				peer_live[hole] = 1'b1;
				peer_id[hole] = hb.heard_id;
				peer_seen[hole] = hb.now_time;
			end else begin
				res.dropped = 1'b1;
			end
		end
		for (int i = 0; i < NPEERS; i++) begin
			if (peer_live[i]) begin
				live++;
				if (peer_id[i] < own_id_cfg)
					below++;
			end
		end
		res.node_count = 5'((live + 1 > SAT_MAX) ? SAT_MAX : live + 1);
		res.own_rank = 5'((below > SAT_MAX) ? SAT_MAX : below);
		return res;
	endfunction

	function automatic void flag_error(string text);
		err_count++;
		if (err_count <= 10)
			$display("%s", text);
	endfunction

	// monitor: results checked before the new heartbeat is predicted
	plt_out_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					flag_error($sformatf("unexpected result: count %0d rank %0d dropped %0d",
						out_data.node_count, out_data.own_rank, out_data.dropped));
				end else begin
					want = outcome_q.pop_front();
					if (out_data.node_count !== want.node_count
							|| out_data.own_rank !== want.own_rank
							|| out_data.dropped !== want.dropped)
						flag_error($sformatf({"result %0d: expected count %0d rank %0d dropped %0d,",
							" got count %0d rank %0d dropped %0d"}, results_taken,
							want.node_count, want.own_rank, want.dropped,
							out_data.node_count, out_data.own_rank, out_data.dropped));
				end
				results_taken++;
			end
			if (in_valid && !in_stall) begin
				outcome_q.insert(outcome_q.size(), heartbeat_outcome(in_data));
				taken_count++;
			end
		end
	end

	// driver: offers queued heartbeats with random gaps
	int in_seen = 0;
	int in_gap = 0;
	bit offering = 1'b0;
	bit in_burst = 1'b0;
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (offering && taken_count != in_seen) begin
				in_seen = taken_count;
				offering = 1'b0;
				if ($urandom_range(0, 39) == 0)
					in_burst = !in_burst;
				in_gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (!offering) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (hb_queue.size() > 0) begin
					in_data <= hb_queue.pop_front();
					offering = 1'b1;
				end
			end
			in_valid <= offering;
		end
	end

	// receiver: random stall after each result, plus the long hold-off
	int rx_seen = 0;
	int rx_wait = 0;
	bit rx_burst = 1'b0;
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (results_taken != rx_seen) begin
				rx_seen = results_taken;
				if ($urandom_range(0, 39) == 0)
					rx_burst = !rx_burst;
				rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (hold_out) begin
				out_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				out_stall <= 1'b1;
				rx_wait--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic queue_heartbeat(logic [31:0] id, logic [62:0] stamp);
		plt_in_t hb;
		hb.heard_id = id;
		hb.now_time = stamp;
		hb_queue.insert(hb_queue.size(), hb);
		queued_count++;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_OWN_NODE_ID:  own_id_cfg = val;
			REG_ALIVE_WINDOW: window_cfg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_quiet();
		while (taken_count != queued_count || outcome_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		logic [31:0] id_pool [24];
		logic [31:0] own;
		logic [31:0] win;
		logic [31:0] hid;
		logic [63:0] clock_now;
		logic [63:0] span;
		logic [63:0] delta;
		int pool_n;
		int n_items;
		int r;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset registers, own id 0, window 10e6
		@(posedge clk);
		queue_heartbeat(32'd0, 63'd0);                    // sender is this node
		for (int k = 1; k <= 16; k++)
			queue_heartbeat(k, 63'd100);                  // fill the table
		queue_heartbeat(32'd17, 63'd100);                 // table full
		queue_heartbeat(32'd9, 63'd200);                  // refresh
		queue_heartbeat(32'd1, 63'd10000101);             // purge, then reuse freed entry
		queue_heartbeat(32'hFFFF_FFFF, TIME_MAX[62:0]);
		queue_heartbeat(32'd7, 63'd50);                   // below window: no purge
		wait_quiet();

		// directed: own id lands on a stored peer, which must go
		write_reg(REG_OWN_NODE_ID, 32'd7);
		write_reg(REG_ALIVE_WINDOW, 32'hFFFF_FFFF);
		@(posedge clk);
		queue_heartbeat(32'd3, 63'd60);
		queue_heartbeat(32'd7, 63'd70);
		queue_heartbeat(32'hFFFF_FFFF, 63'd0);
		wait_quiet();

		for (int p = 0; p < 10; p++) begin
			pool_n = $urandom_range(3, 24);
			for (int k = 0; k < 24; k++)
				if (p == 0 || $urandom_range(0, 1) == 1)
					id_pool[k] = $urandom;
			case (p % 4)
				0: own = 32'h0;
				1: own = 32'hFFFF_FFFF;
				2: own = $urandom;
				default: own = id_pool[$urandom_range(0, pool_n - 1)];
			endcase
			if (p % 4 != 3) begin
				id_pool[0] = own + 32'd1;
				id_pool[1] = own - 32'd1;
			end
			case (p % 6)
				0: win = 32'd0;
				1: win = 32'd50;
				2: win = 32'd1000;
				3: win = WINDOW_RESET;
				4: win = 32'hFFFF_FFFF;
				default: win = $urandom;
			endcase
			write_reg(REG_OWN_NODE_ID, own);
			write_reg(REG_ALIVE_WINDOW, win);
			clock_now = (p % 3 == 0) ? 64'd0 : ({$urandom, $urandom} >> 1);
			if (clock_now > TIME_MAX - 64'h0000_1000_0000_0000)
				clock_now = clock_now - 64'h0000_1000_0000_0000;
			span = {32'b0, win} / 8 + 4;
			n_items = $urandom_range(95, 135);
			@(posedge clk);
			for (int k = 0; k < n_items; k++) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					// time steps back
					delta = {$urandom, $urandom} % (span * 8);
					clock_now = (clock_now > delta) ? clock_now - delta : 64'd0;
				end else if (r < 9) begin
					// jump past the window: ages out everything older
					clock_now = clock_now + {32'b0, win} + 1 + {$urandom, $urandom} % span;
				end else begin
					clock_now = clock_now + {$urandom, $urandom} % span;
				end
				if (clock_now > TIME_MAX)
					clock_now = TIME_MAX;
				r = $urandom_range(0, 99);
				if (r < 5)
					hid = own;
				else if (r < 13)
					hid = $urandom;
				else
					hid = id_pool[$urandom_range(0, pool_n - 1)];
				queue_heartbeat(hid, clock_now[62:0]);
			end
			if (p == 2) begin
				// long receiver hold-off while heartbeats keep coming
				hold_out = 1'b1;
				repeat (400) @(posedge clk);
				hold_out = 1'b0;
			end
			wait_quiet();
		end

		if (err_count == 0)
			$display("peer_liveness_table_tb: clean");
		else
			$display("peer_liveness_table_tb: errors");
		$finish;
	end

	initial begin
		#4000000;
		$display("peer_liveness_table_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire
